// File: hdl/scale_frame_decimal_parser_unit_macros.svh
// Assertion macros shared by the checker files.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef SCALE_FRAME_DECIMAL_PARSER_UNIT_MACROS_SVH
`define SCALE_FRAME_DECIMAL_PARSER_UNIT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent
`define SFDP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check the consequent in the cycle after the antecedent
`define SFDP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/sfdp_pkg.sv
package sfdp_pkg;

    // Frame layout
    localparam int unsigned PosW       = 4;
    localparam logic [3:0]  FrameLen   = 4'd15;
    localparam logic [3:0]  FieldFirst = 4'd2;
    localparam logic [3:0]  FieldLast  = 4'd9;

    // Widths of the scan state and the result
    localparam int unsigned AccW  = 27;
    localparam int unsigned MantW = 28;
    localparam int unsigned FracW = 3;
    localparam logic [2:0]  FracMax = 3'd7;

    // Characters of interest
    localparam logic [7:0] ChMinus   = 8'h2D;
    localparam logic [7:0] ChPlus    = 8'h2B;
    localparam logic [7:0] ChPoint   = 8'h2E;
    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] ChSpace   = 8'h20;
    localparam logic [7:0] ChTab     = 8'h09;
    localparam logic [7:0] ChCr      = 8'h0D;
    localparam logic [7:0] ChZero    = 8'h30;
    localparam logic [7:0] ChNine    = 8'h39;

    // One decoded weight
    typedef struct packed {
        logic signed [MantW-1:0] mantissa;
        logic [FracW-1:0]        frac;
        logic                    valid;
    } result_t;

endpackage

// File: hdl/sfdp_scan.sv
module sfdp_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          char_in,
    output logic                res_fire,
    output sfdp_pkg::result_t   res
);

    logic [sfdp_pkg::PosW-1:0]  pos_reg, pos_next;
    logic                       hdr_neg_reg, hdr_neg_next;
    logic                       fld_neg_reg, fld_neg_next;
    logic [sfdp_pkg::AccW-1:0]  acc_reg, acc_next;
    logic [sfdp_pkg::FracW-1:0] frac_reg, frac_next;
    logic                       point_reg, point_next;
    logic                       digit_reg, digit_next;
    logic                       started_reg, started_next;
    logic                       stopped_reg, stopped_next;

    logic [sfdp_pkg::PosW-1:0]  pos;
    logic [sfdp_pkg::PosW-1:0]  pos_inc;
    logic                       is_digit;
    logic                       is_space;
    logic                       take_digit;
    logic [sfdp_pkg::AccW-1:0]  acc_x10;
    logic [sfdp_pkg::MantW-1:0] mag;
    logic                       neg;

    assign is_digit = (char_in >= sfdp_pkg::ChZero) && (char_in <= sfdp_pkg::ChNine);
    assign is_space = (char_in == sfdp_pkg::ChSpace)
                   || ((char_in >= sfdp_pkg::ChTab) && (char_in <= sfdp_pkg::ChCr));

    // Multiply by ten as two shifts and an add, then add the digit
    assign acc_x10 = sfdp_pkg::AccW'((acc_reg << 3) + (acc_reg << 1))
                   + sfdp_pkg::AccW'(char_in[3:0]);

    // Next scan state for the current character
    always_comb
    begin
        pos          = (pos_reg >= sfdp_pkg::FrameLen) ? '0 : pos_reg;
        hdr_neg_next = hdr_neg_reg;
        fld_neg_next = fld_neg_reg;
        point_next   = point_reg;
        started_next = started_reg;
        stopped_next = stopped_reg;
        take_digit   = 1'b0;

        if (pos == '0)
        begin
            hdr_neg_next = (char_in == sfdp_pkg::ChMinus);
            fld_neg_next = 1'b0;
            point_next   = 1'b0;
            started_next = 1'b0;
            stopped_next = 1'b0;
        end
        else if ((pos >= sfdp_pkg::FieldFirst) && (pos <= sfdp_pkg::FieldLast)
                 && !stopped_reg)
        begin
            if (!started_reg)
            begin
                if (!is_space)
                begin
                    started_next = 1'b1;
                    if ((char_in == sfdp_pkg::ChPlus) || (char_in == sfdp_pkg::ChMinus))
                        fld_neg_next = (char_in == sfdp_pkg::ChMinus);
                    else if (is_digit)
                        take_digit = 1'b1;
                    else if (char_in == sfdp_pkg::ChPoint)
                        point_next = 1'b1;
                    else
                        stopped_next = 1'b1;
                end
            end
            else
            begin
                if (is_digit)
                    take_digit = 1'b1;
                else if ((char_in == sfdp_pkg::ChPoint) && !point_reg)
                    point_next = 1'b1;
                else
                    stopped_next = 1'b1;
            end
        end

        // Accumulate a digit, count it after the point
        if (pos == '0)
        begin
            acc_next   = '0;
            digit_next = 1'b0;
            frac_next  = '0;
        end
        else if (take_digit)
        begin
            acc_next   = acc_x10;
            digit_next = 1'b1;
            frac_next  = (point_reg && (frac_reg < sfdp_pkg::FracMax))
                       ? frac_reg + 1'b1 : frac_reg;
        end
        else
        begin
            acc_next   = acc_reg;
            digit_next = digit_reg;
            frac_next  = frac_reg;
        end

        // Advance the frame position, close on the last byte, drop on newline
        pos_inc  = pos + 1'b1;
        res_fire = (pos_inc == sfdp_pkg::FrameLen);
        pos_next = res_fire ? '0 : pos_inc;
        if (char_in == sfdp_pkg::ChNewline)
            pos_next = '0;
    end

    // Form the signed result from the updated state
    assign mag = {1'b0, acc_next};
    assign neg = hdr_neg_next ^ fld_neg_next;

    always_comb
    begin
        if (digit_next)
        begin
            res.mantissa = neg ? $signed(-mag) : $signed(mag);
            res.frac     = frac_next;
            res.valid    = 1'b1;
        end
        else
        begin
            res.mantissa = '0;
            res.frac     = '0;
            res.valid    = 1'b0;
        end
    end

    // Hold scan state, update on each processed character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            hdr_neg_reg <= 1'b0;
            fld_neg_reg <= 1'b0;
            acc_reg     <= '0;
            frac_reg    <= '0;
            point_reg   <= 1'b0;
            digit_reg   <= 1'b0;
            started_reg <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else if (take)
        begin
            pos_reg     <= pos_next;
            hdr_neg_reg <= hdr_neg_next;
            fld_neg_reg <= fld_neg_next;
            acc_reg     <= acc_next;
            frac_reg    <= frac_next;
            point_reg   <= point_next;
            digit_reg   <= digit_next;
            started_reg <= started_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// File: hdl/scale_frame_decimal_parser_unit.sv
// Weight frame parser: takes one received ASCII character per transaction and
// assembles 15-byte frames (2 header bytes, 8 numeric text bytes, 3 unit bytes,
// 2 terminator bytes); a newline restarts the frame at any point. Each completed
// frame yields one transaction carrying the signed mantissa, the number of digits
// after the point and a valid flag (0 when the numeric field held no digit).
// A character is accepted every cycle while no result waits at the output; it
// is held in the input register and scanned on its way into the result register,
// so a frame's result is registered as its fifteenth character leaves the input
// register. Throughput is set by the single scan step between the two registers,
// one character per cycle, and stalls only while a result waits at the output.
module scale_frame_decimal_parser_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [27:0] weight_mantissa,
    output logic [2:0]         fraction_digits,
    output logic               weight_valid
);

    logic               in_valid_reg;
    logic [7:0]         char_reg;
    logic               out_valid_reg;
    sfdp_pkg::result_t  res_reg;
    logic               advance;
    logic               take;
    logic               res_fire;
    sfdp_pkg::result_t  res;

    // Move the held character on when the result register can take a result
    assign advance  = !out_valid_reg || out_ready;
    assign take     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    // Hold the incoming character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            char_reg <= rx_byte;
    end

    sfdp_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .char_in  (char_reg),
        .res_fire (res_fire),
        .res      (res)
    );

    // Result register, drop on output transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take && res_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take && res_fire)
            res_reg <= res;
    end

    assign out_valid       = out_valid_reg;
    assign weight_mantissa = res_reg.mantissa;
    assign fraction_digits = res_reg.frac;
    assign weight_valid    = res_reg.valid;

endmodule

// File: hdl/sfdp_checker.sv
`include "scale_frame_decimal_parser_unit_macros.svh"

module sfdp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [7:0]         rx_byte,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [27:0] weight_mantissa,
    input logic [2:0]         fraction_digits,
    input logic               weight_valid
);

    // Waiting character stays put
    `SFDP_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(rx_byte))

    // Stalled result stays put
    `SFDP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(weight_mantissa) && $stable(fraction_digits) && $stable(weight_valid))

    // A failed conversion carries zero payload
    `SFDP_ASSERT_SAME(a_invalid_zero, out_valid && !weight_valid, weight_mantissa == 28'sd0 && fraction_digits == 3'd0)

    // Eight text bytes bound the magnitude
    `SFDP_ASSERT_SAME(a_mant_range, out_valid && weight_valid, weight_mantissa <= 28'sd99999999 && weight_mantissa >= -28'sd99999999)

    // A new result follows a character taken into the input register before it
    `SFDP_ASSERT_SAME(a_result_source, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind scale_frame_decimal_parser_unit sfdp_checker u_sfdp_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int ItemTarget  = 1000;
    localparam int QuietFrom   = 850;
    localparam int HoldCycles  = 300;
    localparam int CycleLimit  = 400000;
    localparam int DirRows     = 19;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         rx_byte = 8'h00;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [27:0] weight_mantissa;
    logic [2:0]         fraction_digits;
    logic               weight_valid;

    // Parser state as seen from outside
    logic [3:0]     frame_pos = '0;
    logic           hdr_neg = 1'b0;
    logic           fld_neg = 1'b0;
    logic [sfdp_pkg::AccW-1:0] digit_acc = '0;
    logic [2:0]     frac_cnt = '0;
    logic           point_seen = 1'b0;
    logic           digit_seen = 1'b0;
    logic           scan_on = 1'b0;
    logic           scan_done = 1'b0;

    sfdp_pkg::result_t weight_queue[$];
    int      error_count = 0;
    int      sent_chars = 0;
    int      cycle_count = 0;
    bit      idle_on = 1'b1;
    bit      hold_request = 1'b0;

    // Directed frames; a typed row carries the weight that the frame must give
    string dir_text [DirRows] = '{
        "+    12.34g  \r\n",
        "  12345678kg \r\n",
        "  99999999kg \r\n",
        "- 99999999kg \r\n",
        "  -9999999kg \r\n",
        "- -1.5    g  \r\n",
        "    abc   g  \r\n",
        "          g  \r\n",
        "  .       g  \r\n",
        "- 00000.00g  \r\n",
        "  .1234567g  \r\n",
        "  1.2.3   g  \r\n",
        "- 12\n",
        "+-  42    kg \r\n",
        "  \t\013\014\r7   g  xx",
        "  +0000001g  \r\n",
        "\n",
        "  -+5     g  \r\n",
        "  +       g  \r\n"
    };
    bit dir_typed [DirRows] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 1, 0, 0, 0, 0};
    int dir_mant  [DirRows] = '{1234, 12345678, 99999999, -99999999, -9999999, 15, 0, 0, 0,
                                0, 1234567, 0, 0, 0, 7, 0, 0, 0, 0};
    int dir_frac  [DirRows] = '{2, 0, 0, 0, 0, 1, 0, 0, 0, 2, 7, 0, 0, 0, 0, 0, 0, 0, 0};
    bit dir_valid [DirRows] = '{1, 1, 1, 1, 1, 1, 0, 0, 0, 1, 1, 0, 0, 0, 1, 0, 0, 0, 0};

    scale_frame_decimal_parser_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .weight_mantissa (weight_mantissa),
        .fraction_digits (fraction_digits),
        .weight_valid    (weight_valid)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Accumulate one digit into the magnitude, counting fraction digits
    task automatic take_digit(input logic [7:0] c);
        logic [3:0] d;
        d = 4'(c - sfdp_pkg::ChZero);
        digit_acc  = digit_acc * 27'd10 + {23'd0, d};
        digit_seen = 1'b1;
        if (point_seen && frac_cnt < sfdp_pkg::FracMax)
            frac_cnt = frac_cnt + 3'd1;
    endtask

    // Advance the frame by one character; got is set when a frame completes
    task automatic advance_parser(input logic [7:0] c, output bit got,
                                  output sfdp_pkg::result_t r);
        logic [3:0]                 pos;
        logic                       is_digit;
        logic                       is_space;
        logic [sfdp_pkg::MantW-1:0] mag;
        got = 1'b0;
        r = '0;
        pos = (frame_pos >= sfdp_pkg::FrameLen) ? 4'd0 : frame_pos;
        is_digit = (c >= sfdp_pkg::ChZero) && (c <= sfdp_pkg::ChNine);
        is_space = (c == sfdp_pkg::ChSpace)
                || (c >= sfdp_pkg::ChTab && c <= sfdp_pkg::ChCr);
        if (pos == 4'd0)
        begin
            fld_neg    = 1'b0;
            digit_acc  = '0;
            frac_cnt   = '0;
            point_seen = 1'b0;
            digit_seen = 1'b0;
            scan_on    = 1'b0;
            scan_done  = 1'b0;
            hdr_neg    = (c == sfdp_pkg::ChMinus);
        end
        else if (pos >= sfdp_pkg::FieldFirst && pos <= sfdp_pkg::FieldLast && !scan_done)
        begin
            if (!scan_on)
            begin
                // Skip leading white space, then allow one sign
                if (!is_space)
                begin
                    scan_on = 1'b1;
                    if (c == sfdp_pkg::ChPlus || c == sfdp_pkg::ChMinus)
                        fld_neg = (c == sfdp_pkg::ChMinus);
                    else if (is_digit)
                        take_digit(c);
                    else if (c == sfdp_pkg::ChPoint)
                        point_seen = 1'b1;
                    else
                        scan_done = 1'b1;
                end
            end
            else if (is_digit)
                take_digit(c);
            else if (c == sfdp_pkg::ChPoint && !point_seen)
                point_seen = 1'b1;
            else
                scan_done = 1'b1;
        end
        pos = pos + 4'd1;
        if (pos == sfdp_pkg::FrameLen)
        begin
            got = 1'b1;
            if (digit_seen)
            begin
                mag = {1'b0, digit_acc};
                r.mantissa = (hdr_neg != fld_neg) ? -mag : mag;
                r.frac     = frac_cnt;
                r.valid    = 1'b1;
            end
            pos = 4'd0;
        end
        if (c == sfdp_pkg::ChNewline)
            pos = 4'd0;
        frame_pos = pos;
    endtask

    // Offer one character, hold it until accepted, then predict
    task automatic send_char(input logic [7:0] c, input bit typed,
                             input sfdp_pkg::result_t typed_r);
        bit                got;
        sfdp_pkg::result_t r;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_chars++;
        advance_parser(c, got, r);
        if (got)
            weight_queue.push_back(typed ? typed_r : r);
    endtask

    function automatic logic [7:0] any_but_newline();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        return (c == sfdp_pkg::ChNewline) ? sfdp_pkg::ChSpace : c;
    endfunction

    // Build a mostly well-formed frame with random content; some are cut short
    task automatic send_random_frame();
        logic [7:0]        fr [15];
        sfdp_pkg::result_t none;
        int                lead;
        int                sgn;
        int                dig_end;
        int                pt;
        int                cut;
        int                k;
        none = '0;
        case ($urandom_range(0, 3))
            0: fr[0] = sfdp_pkg::ChMinus;
            1: fr[0] = sfdp_pkg::ChPlus;
            2: fr[0] = sfdp_pkg::ChSpace;
            default: fr[0] = any_but_newline();
        endcase
        fr[1] = ($urandom_range(0, 1) == 0) ? sfdp_pkg::ChSpace : any_but_newline();
        lead    = $urandom_range(0, 3);
        sgn     = $urandom_range(0, 2);
        dig_end = $urandom_range(lead + 1, 8);
        pt      = ($urandom_range(0, 3) == 0) ? 99 : $urandom_range(lead, 7);
        for (k = 0; k < 8; k++)
        begin
            if (k < lead)
            begin
                fr[2 + k] = sfdp_pkg::ChTab + 8'($urandom_range(0, 4));
                if (fr[2 + k] == sfdp_pkg::ChNewline)
                    fr[2 + k] = sfdp_pkg::ChSpace;
            end
            else if (k == lead && sgn != 0)
                fr[2 + k] = (sgn == 1) ? sfdp_pkg::ChPlus : sfdp_pkg::ChMinus;
            else if (k == pt)
                fr[2 + k] = sfdp_pkg::ChPoint;
            else if (k < dig_end)
                fr[2 + k] = sfdp_pkg::ChZero + 8'($urandom_range(0, 9));
            else
                fr[2 + k] = ($urandom_range(0, 1) == 0) ? sfdp_pkg::ChSpace
                                                        : any_but_newline();
        end
        for (k = 10; k < 13; k++)
            fr[k] = any_but_newline();
        if ($urandom_range(0, 3) != 0)
        begin
            fr[13] = sfdp_pkg::ChCr;
            fr[14] = sfdp_pkg::ChNewline;
        end
        else
        begin
            fr[13] = any_but_newline();
            fr[14] = 8'($urandom_range(0, 255));
        end
        // Break one frame in eight with an early newline
        cut = 14;
        if ($urandom_range(0, 7) == 0)
        begin
            cut = $urandom_range(0, 13);
            fr[cut] = sfdp_pkg::ChNewline;
        end
        for (k = 0; k <= cut; k++)
            send_char(fr[k], 1'b0, none);
    endtask

    // Stimulus
    initial
    begin
        sfdp_pkg::result_t typed_r;
        sfdp_pkg::result_t none;
        int                i;
        int                k;
        none = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames
        for (i = 0; i < DirRows; i++)
        begin
            typed_r.mantissa = dir_mant[i][sfdp_pkg::MantW-1:0];
            typed_r.frac     = dir_frac[i][sfdp_pkg::FracW-1:0];
            typed_r.valid    = dir_valid[i];
            for (k = 0; k < dir_text[i].len(); k++)
                send_char(dir_text[i][k], dir_typed[i], typed_r);
        end

        // Random frames with noise bursts; the output holds off once early on
        hold_request = 1'b1;
        while (sent_chars < ItemTarget)
        begin
            idle_on = (sent_chars < QuietFrom) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 20))
                    send_char(8'($urandom_range(0, 255)), 1'b0, none);
                send_char(sfdp_pkg::ChNewline, 1'b0, none);
            end
            else
                send_random_frame();
        end
        idle_on = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain
        while (weight_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (weight_queue.size() != 0)
        begin
            $display("%0t: %0d expected weights never arrived", $time, weight_queue.size());
            error_count++;
        end
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Output side: random stalls plus one long hold-off
    initial
    begin
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HoldCycles) @(negedge clk);
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expected weight
    always @(posedge clk)
    begin
        sfdp_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (weight_queue.size() == 0)
            begin
                $display("%0t: unexpected weight mantissa=%0d frac=%0d valid=%0d", $time,
                         weight_mantissa, fraction_digits, weight_valid);
                error_count++;
            end
            else
            begin
                want = weight_queue.pop_front();
                if (weight_mantissa !== want.mantissa)
                begin
                    $display("%0t: weight_mantissa expected %0d actual %0d", $time,
                             want.mantissa, weight_mantissa);
                    error_count++;
                end
                if (fraction_digits !== want.frac)
                begin
                    $display("%0t: fraction_digits expected %0d actual %0d", $time,
                             want.frac, fraction_digits);
                    error_count++;
                end
                if (weight_valid !== want.valid)
                begin
                    $display("%0t: weight_valid expected %0d actual %0d", $time,
                             want.valid, weight_valid);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count == CycleLimit)
            begin
                $display("%0t: cycle limit reached", $time);
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
